/* hw/rtl/fprs_pkg.sv */
package fprs_pkg;

   localparam int AlphaBitsDef = 32;
   localparam int MaxRangesDef = 3;
   localparam int RangeCnt     = 3;
   localparam int RateW        = 32;
   // upper slice of the alpha word, enough for the widest alpha
   localparam int AlphaHiW     = 9;

   localparam logic [2:0] CSR_NUM_RANGES  = 3'd0;
   localparam logic [2:0] CSR_RANGE0_LOW  = 3'd1;
   localparam logic [2:0] CSR_RANGE0_HIGH = 3'd2;
   localparam logic [2:0] CSR_RANGE1_LOW  = 3'd3;
   localparam logic [2:0] CSR_RANGE1_HIGH = 3'd4;
   localparam logic [2:0] CSR_RANGE2_LOW  = 3'd5;
   localparam logic [2:0] CSR_RANGE2_HIGH = 3'd6;

   typedef struct packed {
      logic        bad_parent;
      logic [31:0] rounded_rate;
      logic        range_found;
      logic [1:0]  range_index;
      logic [31:0] achieved_rate;
      logic [32:0] alpha_frac;
      logic [31:0] int_mult;
   } rsp_type;

endpackage

/* hw/rtl/fprs_div_cell.sv */
module fprs_div_cell import fprs_pkg::*; #(
   parameter int QW = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             valid_i,
   input  logic             bad_i,
   input  logic [31:0]      t_i,
   input  logic [31:0]      p_i,
   input  logic [31:0]      rem_i,
   input  logic [QW-1:0]    q_i,
   output logic             valid_o,
   output logic             bad_o,
   output logic [31:0]      t_o,
   output logic [31:0]      p_o,
   output logic [31:0]      rem_o,
   output logic [QW-1:0]    q_o
);
   logic          valid_ff, bad_ff;
   logic [31:0]   t_ff, p_ff, rem_ff, rem_in;
   logic [QW-1:0] q_ff;
   logic [32:0]   rem2, diff;
   logic          ge;

   // one restoring step: bring down the next dividend bit
   assign rem2   = {rem_i, t_i[31]};
   assign diff   = rem2 - {1'b0, p_i};
   assign ge     = rem2 >= {1'b0, p_i};
   assign rem_in = ge ? diff[31:0] : rem2[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         bad_ff <= bad_i;
         t_ff   <= {t_i[30:0], 1'b0};
         p_ff   <= p_i;
         rem_ff <= rem_in;
         q_ff   <= {q_i[QW-2:0], ge};
      end
   end

   assign valid_o = valid_ff;
   assign bad_o   = bad_ff;
   assign t_o     = t_ff;
   assign p_o     = p_ff;
   assign rem_o   = rem_ff;
   assign q_o     = q_ff;
endmodule

/* hw/rtl/fprs_rebuild.sv */
module fprs_rebuild import fprs_pkg::*; #(
   parameter int ALPHA_BITS = AlphaBitsDef
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       valid_i,
   input  logic                       bad_i,
   input  logic [31:0]                p_i,
   input  logic [31:0]                rem_i,
   input  logic [32+ALPHA_BITS-1:0]   q_i,
   output logic                       valid_o,
   output logic                       bad_o,
   output logic [31:0]                int_o,
   output logic [32:0]                alpha_o,
   output logic [31:0]                rate_o
);
   localparam int AW = ALPHA_BITS + 1;

   logic [3:0]    valid_ff;
   logic [3:0]    bad_ff;
   // ceiling stage
   logic [31:0]   int_c_ff, p_c_ff;
   logic [AW-1:0] alpha_c_ff, alpha_c_in;
   // multiply stage
   logic [31:0]   int_m_ff;
   logic [63:0]   alpha64, a_m_ff;
   logic [63:0]   pl_ff, pl_in, plo_ff, plo_in;
   logic [AlphaHiW+31:0] phi_ff, phi_in;
   // partial product sum
   logic [31:0]   int_s_ff;
   logic [63:0]   a_s_ff, pl_s_ff;
   logic [72:0]   full_ff, full_in;
   // final add
   logic [31:0]   int_r_ff, rate_ff, rate_in;
   logic [63:0]   a_r_ff;
   logic [32:0]   sum;

   assign alpha_c_in = {1'b0, q_i[ALPHA_BITS-1:0]} + AW'(rem_i != 32'd0);
   assign alpha64    = 64'(alpha_c_ff);
   assign pl_in      = p_c_ff * int_c_ff;
   assign plo_in     = p_c_ff * alpha64[31:0];
   assign phi_in     = p_c_ff * alpha64[32+AlphaHiW-1:32];
   assign full_in    = 73'(plo_ff) + (73'(phi_ff) << 32);
   assign sum        = 33'(pl_s_ff[31:0]) + 33'(full_ff >> ALPHA_BITS);
   assign rate_in    = sum[32] ? '1 : sum[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], valid_i};
      end
      if (en) begin
         bad_ff     <= {bad_ff[2:0], bad_i};
         int_c_ff   <= q_i[32+ALPHA_BITS-1:ALPHA_BITS];
         p_c_ff     <= p_i;
         alpha_c_ff <= alpha_c_in;
         int_m_ff   <= int_c_ff;
         a_m_ff     <= alpha64;
         pl_ff      <= pl_in;
         plo_ff     <= plo_in;
         phi_ff     <= phi_in;
         int_s_ff   <= int_m_ff;
         a_s_ff     <= a_m_ff;
         pl_s_ff    <= pl_ff;
         full_ff    <= full_in;
         int_r_ff   <= int_s_ff;
         a_r_ff     <= a_s_ff;
         rate_ff    <= rate_in;
      end
   end

   assign valid_o = valid_ff[3];
   assign bad_o   = bad_ff[3];
   assign int_o   = int_r_ff;
   assign alpha_o = 33'(a_r_ff);
   assign rate_o  = rate_ff;
endmodule

/* hw/rtl/fprs_range.sv */
module fprs_range import fprs_pkg::*; #(
   parameter int MAX_RANGES = MaxRangesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        valid_i,
   input  logic        bad_i,
   input  logic [31:0] int_i,
   input  logic [32:0] alpha_i,
   input  logic [31:0] rate_i,
   input  logic [1:0]  num_ranges_i,
   input  logic [31:0] range_lo_i [RangeCnt],
   input  logic [31:0] range_hi_i [RangeCnt],
   output logic        valid_o,
   output rsp_type     rsp_o
);
   logic          valid_ff;
   rsp_type       rsp_ff, rsp_in;
   logic [1:0]    n_eff, idx;
   logic [RangeCnt-1:0] hit;
   logic [31:0]   hi_b, raised, rounded;

   always_comb begin
      if (num_ranges_i == 2'd0) begin
         n_eff = 2'd1;
      end else if (32'(num_ranges_i) > 32'(MAX_RANGES)) begin
         n_eff = 2'(MAX_RANGES);
      end else begin
         n_eff = num_ranges_i;
      end
      for (int i = 0; i < RangeCnt; i++) begin
         hit[i] = (2'(i) < n_eff) && (rate_i >= range_lo_i[i]) && (rate_i <= range_hi_i[i]);
      end
      idx = 2'd0;
      for (int i = RangeCnt - 1; i >= 0; i--) begin
         if (hit[i]) begin
            idx = 2'(i);
         end
      end
      hi_b    = range_hi_i[n_eff - 2'd1];
      raised  = (rate_i < range_lo_i[0]) ? range_lo_i[0] : rate_i;
      rounded = (raised > hi_b) ? hi_b : raised;

      rsp_in = '0;
      rsp_in.bad_parent = bad_i;
      if (!bad_i) begin
         rsp_in.int_mult      = int_i;
         rsp_in.alpha_frac    = alpha_i;
         rsp_in.achieved_rate = rate_i;
         rsp_in.range_found   = |hit;
         rsp_in.range_index   = idx;
         rsp_in.rounded_rate  = (|hit) ? rate_i : rounded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign valid_o = valid_ff;
   assign rsp_o   = rsp_ff;
endmodule

/* hw/rtl/fractional_pll_rate_solver.sv */
// from input transfer to result: 32 + ALPHA_BITS divider cells, four rebuild stages,
// one range stage and the result buffer
// throughput: one transfer per cycle while the result buffer has a free slot; the
// whole row advances together, and the two-entry result buffer keeps rsp_tready out
// of the combinational path to req_tready
// reset: synchronous, clears all valid bits and the buffer, range registers
// return to one range spanning the full 32-bit rate
module fractional_pll_rate_solver import fprs_pkg::*; #(
   parameter int ALPHA_BITS = AlphaBitsDef,
   parameter int MAX_RANGES = MaxRangesDef
) (
   input  logic         clock,
   input  logic         reset,
   // target_rate [31:0], ref_rate [63:32]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,
   // int_mult [31:0], alpha_frac [64:32], achieved_rate [96:65],
   // range_index [98:97], rounded_rate [130:99], zero fill [135:131]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,
   // range_found [0], bad_parent [1]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   localparam int NCell = 32 + ALPHA_BITS;
   localparam int QW    = 32 + ALPHA_BITS;

   // configuration registers
   logic [1:0]  num_ranges_ff;
   logic [31:0] range_lo_ff [RangeCnt];
   logic [31:0] range_hi_ff [RangeCnt];

   // row of divider cells, one quotient bit each
   logic          c_valid [NCell+1];
   logic          c_bad   [NCell+1];
   logic [31:0]   c_t     [NCell+1];
   logic [31:0]   c_p     [NCell+1];
   logic [31:0]   c_rem   [NCell+1];
   logic [QW-1:0] c_q     [NCell+1];

   logic        en;
   logic        rb_valid, rb_bad;
   logic [31:0] rb_int, rb_rate;
   logic [32:0] rb_alpha;
   logic        rg_valid;
   rsp_type     rg_rsp;

   // result buffer
   rsp_type     buf_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        push, pop;
   rsp_type     head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ranges_ff <= 2'd1;
         for (int i = 0; i < RangeCnt; i++) begin
            range_lo_ff[i] <= '0;
            range_hi_ff[i] <= '0;
         end
         range_hi_ff[0] <= '1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_RANGES:  num_ranges_ff  <= csr_data[1:0];
            CSR_RANGE0_LOW:  range_lo_ff[0] <= csr_data;
            CSR_RANGE0_HIGH: range_hi_ff[0] <= csr_data;
            CSR_RANGE1_LOW:  range_lo_ff[1] <= csr_data;
            CSR_RANGE1_HIGH: range_hi_ff[1] <= csr_data;
            CSR_RANGE2_LOW:  range_lo_ff[2] <= csr_data;
            CSR_RANGE2_HIGH: range_hi_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // the row moves whenever the buffer has a free slot
   assign en         = (count_ff != 2'd2);
   assign req_tready = en;

   assign c_valid[0] = req_tvalid;
   assign c_bad[0]   = (req_tdata[63:32] == 32'd0);
   assign c_t[0]     = req_tdata[31:0];
   assign c_p[0]     = req_tdata[63:32];
   assign c_rem[0]   = '0;
   assign c_q[0]     = '0;

   for (genvar k = 0; k < NCell; k++) begin : g_cell
      fprs_div_cell #(.QW(QW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .valid_i (c_valid[k]),
         .bad_i   (c_bad[k]),
         .t_i     (c_t[k]),
         .p_i     (c_p[k]),
         .rem_i   (c_rem[k]),
         .q_i     (c_q[k]),
         .valid_o (c_valid[k+1]),
         .bad_o   (c_bad[k+1]),
         .t_o     (c_t[k+1]),
         .p_o     (c_p[k+1]),
         .rem_o   (c_rem[k+1]),
         .q_o     (c_q[k+1])
      );
   end

   // round alpha up and rebuild the achievable rate
   fprs_rebuild #(.ALPHA_BITS(ALPHA_BITS)) u_rebuild (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (c_valid[NCell]),
      .bad_i   (c_bad[NCell]),
      .p_i     (c_p[NCell]),
      .rem_i   (c_rem[NCell]),
      .q_i     (c_q[NCell]),
      .valid_o (rb_valid),
      .bad_o   (rb_bad),
      .int_o   (rb_int),
      .alpha_o (rb_alpha),
      .rate_o  (rb_rate)
   );

   // vco range lookup and clamp
   fprs_range #(.MAX_RANGES(MAX_RANGES)) u_range (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .valid_i      (rb_valid),
      .bad_i        (rb_bad),
      .int_i        (rb_int),
      .alpha_i      (rb_alpha),
      .rate_i       (rb_rate),
      .num_ranges_i (num_ranges_ff),
      .range_lo_i   (range_lo_ff),
      .range_hi_i   (range_hi_ff),
      .valid_o      (rg_valid),
      .rsp_o        (rg_rsp)
   );

   assign push = en && rg_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= rg_rsp;
      end
   end

   assign head       = buf_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {5'd0, head.rounded_rate, head.range_index, head.achieved_rate,
                        head.alpha_frac, head.int_mult};
   assign rsp_tuser  = {head.bad_parent, head.range_found};
endmodule

/* hw/rtl/fprs_checker.sv */
module fprs_checker import fprs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);
   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // zero parent gives an all-zero result
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 136'd0 && !rsp_tuser[0])
      else $error("bad parent result not cleared");

   // unmatched rate reports range zero
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[98:97] == 2'd0)
      else $error("index set without a match");

   // matched rate passes through unclamped
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[130:99] == rsp_tdata[96:65]
         && rsp_tdata[98:97] != 2'd3)
      else $error("matched rate was altered");
endmodule

bind fractional_pll_rate_solver fprs_checker u_fprs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
